### rtl/core/linear_recurrence_matrix_power_mod_core_macros.svh
// Assertion helpers shared by the core modules.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LINEAR_RECURRENCE_MATRIX_POWER_MOD_CORE_MACROS_SVH
`define LINEAR_RECURRENCE_MATRIX_POWER_MOD_CORE_MACROS_SVH

// Same-cycle implication.
`define LRMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LRMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lrmp_pkg.sv
`timescale 1ns / 1ps

package lrmp_pkg;

	localparam int TERM_W = 32;
	localparam int COEF_W = 16;
	localparam int MOD_W = 16;
	localparam int MU_W = 32;
	localparam int INDEX_BITS_DEF = 32;

	// 4x4 matrix: 16 entries, row-major address {row, col}
	localparam int ADDR_W = 4;
	localparam int MAC_CNT_W = 6;

	localparam logic [MOD_W-1:0] MODULUS_RESET = 16'd10007;
	// Barrett reciprocal floor(2^32 / modulus) for the reset modulus
	localparam logic [MU_W-1:0] MU_RESET = MU_W'((64'd1 << 32) / 64'(MODULUS_RESET));

	localparam logic [MAC_CNT_W-1:0] LAST_MAC = '1;
	localparam logic [ADDR_W-1:0] LAST_ENTRY = '1;
	// entry (row 0, col 3) holds the answer
	localparam logic [ADDR_W-1:0] RESULT_ADDR = 4'h3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INIT,
		ST_SQ,
		ST_SQ_DRAIN,
		ST_MUL,
		ST_MUL_DRAIN,
		ST_NEXT,
		ST_READ,
		ST_FINISH
	} lrmp_state_t;

	typedef struct packed {
		logic issue;
		logic sq;
		logic first;
		logic last;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
		logic [ADDR_W-1:0] waddr;
		logic init_we;
		logic load_item;
		logic swap;
		logic ex_shift;
		logic load_out;
	} lrmp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic ex_msb;
		logic trivial;
		logic out_free;
	} lrmp_stat_t;

endpackage

### rtl/core/lrmp_if.sv
`timescale 1ns / 1ps

interface lrmp_in_if;
	import lrmp_pkg::*;
	logic valid;
	logic ready;
	logic [TERM_W-1:0] term_index;
	logic [COEF_W-1:0] coeff_a;
	logic [COEF_W-1:0] coeff_b;
	logic [COEF_W-1:0] coeff_c;
	modport source (output valid, term_index, coeff_a, coeff_b, coeff_c, input ready);
	modport sink (input valid, term_index, coeff_a, coeff_b, coeff_c, output ready);
endinterface

interface lrmp_out_if;
	import lrmp_pkg::*;
	logic valid;
	logic ready;
	logic [MOD_W-1:0] term_value;
	modport source (output valid, term_value, input ready);
	modport sink (input valid, term_value, output ready);
endinterface

### rtl/core/lrmp_mudiv.sv
`timescale 1ns / 1ps

module lrmp_mudiv (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [lrmp_pkg::MOD_W-1:0] divisor,
	output logic busy,
	output logic [lrmp_pkg::MU_W-1:0] mu
);
	import lrmp_pkg::*;

	localparam int STEP_W = $clog2(MU_W + 1);

	logic [MOD_W-1:0] div_q;
	logic [MOD_W-1:0] rem_q;
	logic [MU_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic [MOD_W:0] rem_sh;
	logic take;

	// one restoring step: shift in a zero bit of 2^32, subtract if it fits
	assign rem_sh = {rem_q, 1'b0};
	assign take = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			quo_q <= MU_RESET;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			quo_q <= '0;
			step_q <= STEP_W'(MU_W);
		end else if (busy_q) begin
			quo_q <= {quo_q[MU_W-2:0], take};
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	// working registers; leading dividend bit is already folded into rem
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= MOD_W'(1);
		end else if (busy_q) begin
			rem_q <= take ? MOD_W'(rem_sh - {1'b0, div_q}) : rem_sh[MOD_W-1:0];
		end
	end

	assign busy = busy_q;
	assign mu = quo_q;

endmodule

### rtl/core/lrmp_ctrl.sv
`timescale 1ns / 1ps
`include "linear_recurrence_matrix_power_mod_core_macros.svh"

module lrmp_ctrl #(
	parameter int INDEX_BITS = lrmp_pkg::INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic cfg_we,
	input  logic div_busy,
	input  lrmp_pkg::lrmp_stat_t stat,
	output lrmp_pkg::lrmp_cmd_t cmd
);
	import lrmp_pkg::*;

	localparam int BIT_W = $clog2(INDEX_BITS + 1);

	lrmp_state_t state_q, state_d;
	logic [MAC_CNT_W-1:0] cnt_q, cnt_d;
	logic [BIT_W-1:0] bits_q, bits_d;

	// hold state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			bits_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			bits_q <= bits_d;
		end
	end

	// unless trivial: identity load, then per exponent bit square, maybe multiply
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		bits_d = bits_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.raddr_a = {cnt_q[5:4], cnt_q[1:0]};
		cmd.raddr_b = {cnt_q[1:0], cnt_q[3:2]};
		cmd.waddr = cnt_q[5:2];
		cmd.first = cnt_q[1:0] == 2'd0;
		cmd.last = cnt_q[1:0] == 2'd3;
		case (state_q)
			ST_IDLE: begin
				in_ready = !div_busy && !cfg_we;
				if (in_valid && in_ready) begin
					cmd.load_item = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cnt_d = '0;
				bits_d = BIT_W'(INDEX_BITS);
				state_d = stat.trivial ? ST_FINISH : ST_INIT;
			end
			ST_INIT: begin
				cmd.init_we = 1'b1;
				cmd.waddr = cnt_q[ADDR_W-1:0];
				cnt_d = cnt_q + 1'b1;
				if (cnt_q[ADDR_W-1:0] == LAST_ENTRY) begin
					cnt_d = '0;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.issue = 1'b1;
				cmd.sq = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_MAC)
					state_d = ST_SQ_DRAIN;
			end
			ST_SQ_DRAIN: begin
				if (!stat.pipe_busy) begin
					cmd.swap = 1'b1;
					state_d = stat.ex_msb ? ST_MUL : ST_NEXT;
				end
			end
			ST_MUL: begin
				cmd.issue = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_MAC)
					state_d = ST_MUL_DRAIN;
			end
			ST_MUL_DRAIN: begin
				if (!stat.pipe_busy) begin
					cmd.swap = 1'b1;
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				cmd.ex_shift = 1'b1;
				bits_d = bits_q - 1'b1;
				state_d = (bits_q == BIT_W'(1)) ? ST_READ : ST_SQ;
			end
			ST_READ: begin
				cmd.raddr_a = RESULT_ADDR;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.raddr_a = RESULT_ADDR;
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`LRMP_ASSERT_NOW(a_issue_not_div, cmd.issue, !div_busy, "issue while reciprocal busy")
	`LRMP_ASSERT_NOW(a_swap_drained, cmd.swap, !stat.pipe_busy, "bank swap with MACs in flight")
	`LRMP_ASSERT_NEXT(a_accept_check, in_valid && in_ready, state_q == ST_CHECK,
		"accepted request not checked")

endmodule

### rtl/core/lrmp_dp.sv
`timescale 1ns / 1ps
`include "linear_recurrence_matrix_power_mod_core_macros.svh"

module lrmp_dp #(
	parameter int INDEX_BITS = lrmp_pkg::INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  lrmp_pkg::lrmp_cmd_t cmd,
	output lrmp_pkg::lrmp_stat_t stat,
	input  logic [lrmp_pkg::TERM_W-1:0] term_index,
	input  logic [lrmp_pkg::COEF_W-1:0] coeff_a,
	input  logic [lrmp_pkg::COEF_W-1:0] coeff_b,
	input  logic [lrmp_pkg::COEF_W-1:0] coeff_c,
	input  logic cfg_we,
	input  logic [lrmp_pkg::MOD_W-1:0] cfg_wdata,
	input  logic [lrmp_pkg::MU_W-1:0] mu,
	input  logic out_ready,
	output logic out_valid,
	output logic [lrmp_pkg::MOD_W-1:0] term_value
);
	import lrmp_pkg::*;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic [ADDR_W-1:0] waddr;
	} mac_tag_t;

	logic [MOD_W-1:0] mod_q;
	logic [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
	logic [INDEX_BITS-1:0] ex_q;
	logic [INDEX_BITS-1:0] ex_init;
	logic [TERM_W-1:0] nm2;
	logic trivial_q;
	logic sel_q;

	logic [MOD_W-1:0] mem0_q [2**ADDR_W];
	logic [MOD_W-1:0] mem1_q [2**ADDR_W];
	logic [MOD_W-1:0] rda0_s1, rdb0_s1, rda1_s1, rdb1_s1;
	logic src_s1, sq_s1;
	logic [ADDR_W-1:0] kj_s1;
	mac_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic [MOD_W-1:0] x_s1, y_s1;
	logic [2*MOD_W-1:0] prod_s2, prod_s3, prod_s4, qm_s4;
	logic [2*MU_W-1:0] bar;
	logic [MU_W-1:0] q_s3;
	logic [MOD_W+1:0] rdiff, mod2;
	logic [MOD_W-1:0] res_s5, acc_q, acc_d;
	logic [MOD_W:0] sum;
	logic mac_we;
	logic [ADDR_W-1:0] w_addr;
	logic [MOD_W-1:0] w_data;
	logic out_valid_q;
	logic [MOD_W-1:0] out_q;

	// transition matrix entry at {row k, col j}
	function automatic logic [MOD_W-1:0] tmat(input logic [ADDR_W-1:0] kj,
			input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
			input logic [COEF_W-1:0] c);
		logic [MOD_W-1:0] v;
		case (kj)
			4'h0: v = a;
			4'h2: v = b;
			4'h3: v = c;
			4'h4, 4'h9, 4'hF: v = MOD_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	// exponent n-2 folded to the scan width
	assign nm2 = term_index - TERM_W'(2);
	if (INDEX_BITS <= TERM_W) begin : g_ex_narrow
		assign ex_init = nm2[INDEX_BITS-1:0];
	end else begin : g_ex_wide
		assign ex_init = {{(INDEX_BITS - TERM_W){1'b0}}, nm2};
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mod_q <= MODULUS_RESET;
		else if (cfg_we)
			mod_q <= cfg_wdata;
	end

	// capture request, scan exponent from its top bit
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			coef_a_q <= coeff_a;
			coef_b_q <= coeff_b;
			coef_c_q <= coeff_c;
			ex_q <= ex_init;
			trivial_q <= (term_index <= TERM_W'(2)) || (mod_q < MOD_W'(2));
		end else if (cmd.ex_shift) begin
			ex_q <= {ex_q[INDEX_BITS-2:0], 1'b0};
		end
	end

	// ping-pong bank select: read sel_q, write the other
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= 1'b0;
		else if (cmd.swap)
			sel_q <= !sel_q;
	end

	// bank writes: identity load goes to the source bank, MAC results to the other
	assign mac_we = tag_s5.valid && tag_s5.last;
	assign w_addr = cmd.init_we ? cmd.waddr : tag_s5.waddr;
	assign w_data = cmd.init_we ?
		MOD_W'(cmd.waddr[3:2] == cmd.waddr[1:0]) : acc_d;

	always_ff @(posedge clk) begin
		if ((cmd.init_we && !sel_q) || (mac_we && sel_q))
			mem0_q[w_addr] <= w_data;
		if ((cmd.init_we && sel_q) || (mac_we && !sel_q))
			mem1_q[w_addr] <= w_data;
		rda0_s1 <= mem0_q[cmd.raddr_a];
		rdb0_s1 <= mem0_q[cmd.raddr_b];
		rda1_s1 <= mem1_q[cmd.raddr_a];
		rdb1_s1 <= mem1_q[cmd.raddr_b];
		src_s1 <= sel_q;
		sq_s1 <= cmd.sq;
		kj_s1 <= cmd.raddr_b;
	end

	// stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1 <= '{valid: cmd.issue, first: cmd.first, last: cmd.last,
				waddr: cmd.waddr};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	// operand select: P*P when squaring, P*T otherwise
	assign x_s1 = src_s1 ? rda1_s1 : rda0_s1;
	assign y_s1 = sq_s1 ? (src_s1 ? rdb1_s1 : rdb0_s1) :
		tmat(kj_s1, coef_a_q, coef_b_q, coef_c_q);

	// Barrett estimate: q = (x * mu) >> 32, short by at most one
	assign bar = 64'(prod_s2) * 64'(mu);
	assign rdiff = (MOD_W + 2)'(prod_s4 - qm_s4);
	assign mod2 = {1'b0, mod_q, 1'b0};

	always_ff @(posedge clk) begin
		prod_s2 <= 32'(x_s1) * 32'(y_s1);
		prod_s3 <= prod_s2;
		q_s3 <= bar[2*MU_W-1:MU_W];
		prod_s4 <= prod_s3;
		qm_s4 <= 32'(q_s3) * 32'(mod_q);
		if (rdiff >= mod2)
			res_s5 <= MOD_W'(rdiff - mod2);
		else if (rdiff >= {2'b00, mod_q})
			res_s5 <= MOD_W'(rdiff - {2'b00, mod_q});
		else
			res_s5 <= rdiff[MOD_W-1:0];
	end

	// accumulate the four residues of one entry
	assign sum = tag_s5.first ? {1'b0, res_s5} : ({1'b0, acc_q} + {1'b0, res_s5});
	assign acc_d = (sum >= {1'b0, mod_q}) ? MOD_W'(sum - {1'b0, mod_q}) : sum[MOD_W-1:0];

	always_ff @(posedge clk) begin
		if (tag_s5.valid)
			acc_q <= acc_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_q <= trivial_q ? '0 : x_s1;
	end

	assign out_valid = out_valid_q;
	assign term_value = out_q;

	assign stat.pipe_busy = tag_s1.valid || tag_s2.valid || tag_s3.valid ||
		tag_s4.valid || tag_s5.valid;
	assign stat.ex_msb = ex_q[INDEX_BITS-1];
	assign stat.trivial = trivial_q;
	assign stat.out_free = !out_valid_q || out_ready;

	`LRMP_ASSERT_NOW(a_res_reduced, tag_s5.valid, res_s5 < mod_q, "product residue not reduced")
	`LRMP_ASSERT_NOW(a_init_idle, cmd.init_we, !stat.pipe_busy, "identity load with MACs in flight")
	`LRMP_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_q || out_ready,
		"result overwrites pending response")

endmodule

### rtl/core/linear_recurrence_matrix_power_mod_core.sv
`timescale 1ns / 1ps

// Returns f(n) mod m for f(k) = a*f(k-1) + b*f(k-3) + c, f(0..2) = 0, by raising
// the 4x4 transition matrix to the power n-2 (square-and-multiply over INDEX_BITS
// exponent bits, MSB first). One request is worked at a time; every matrix
// product runs 64 multiply-accumulates through one pipelined Barrett modular
// multiplier, one per cycle, then waits for the pipeline to drain. n <= 2 or
// m < 2 answers 0. A finished result waits in an output register, so the next
// request is accepted while it is unread. Writing the modulus starts a
// reciprocal computation during which no request is accepted.
module linear_recurrence_matrix_power_mod_core #(
	parameter int INDEX_BITS = lrmp_pkg::INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lrmp_in_if.sink in_ch,
	lrmp_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [lrmp_pkg::MOD_W-1:0] cfg_wdata
);
	import lrmp_pkg::*;

	lrmp_cmd_t cmd;
	lrmp_stat_t stat;
	logic div_busy;
	logic [MU_W-1:0] mu;

	lrmp_mudiv u_mudiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(cfg_we),
		.divisor(cfg_wdata),
		.busy(div_busy),
		.mu(mu)
	);

	lrmp_ctrl #(.INDEX_BITS(INDEX_BITS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.cfg_we(cfg_we),
		.div_busy(div_busy),
		.stat(stat),
		.cmd(cmd)
	);

	lrmp_dp #(.INDEX_BITS(INDEX_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.term_index(in_ch.term_index),
		.coeff_a(in_ch.coeff_a),
		.coeff_b(in_ch.coeff_b),
		.coeff_c(in_ch.coeff_c),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mu(mu),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.term_value(out_ch.term_value)
	);

endmodule

### tb/lrmp_checker.sv
`timescale 1ns / 1ps

module lrmp_checker (
	input  logic clk,
	input  logic arst_n,
	lrmp_in_if.sink in_ch,
	lrmp_out_if.sink out_ch,
	input  logic cfg_we,
	input  logic [lrmp_pkg::MOD_W-1:0] cfg_wdata,
	output int errors,
	output int pending
);
	import lrmp_pkg::*;

	typedef logic [3:0][3:0][15:0] mat_t;

	logic [MOD_W-1:0] modulus_q;
	logic [MOD_W-1:0] term_queue[$];

	// One modular matrix product, reducing after every multiply-accumulate
	function automatic mat_t mat_mul_mod(mat_t x, mat_t y, logic [63:0] md);
		mat_t r;
		logic [63:0] acc;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc = (acc + (64'(x[i][k]) % md) * (64'(y[k][j]) % md)) % md;
				r[i][j] = acc[15:0];
			end
		return r;
	endfunction

	// f(n) mod md by square-and-multiply of the transition matrix, MSB first
	function automatic logic [MOD_W-1:0] recurrence_term(logic [TERM_W-1:0] n,
			logic [COEF_W-1:0] a, logic [COEF_W-1:0] b, logic [COEF_W-1:0] c,
			logic [MOD_W-1:0] md);
		mat_t step_m;
		mat_t pow_m;
		logic [TERM_W-1:0] ex;
		if (n <= 2 || md < 2)
			return '0;
		ex = n - 2;
		step_m = '0;
		step_m[0][0] = a;
		step_m[0][2] = b;
		step_m[0][3] = c;
		step_m[1][0] = 1;
		step_m[2][1] = 1;
		step_m[3][3] = 1;
		pow_m = '0;
		for (int i = 0; i < 4; i++)
			pow_m[i][i] = 1;
		for (int bt = TERM_W - 1; bt >= 0; bt--) begin
			pow_m = mat_mul_mod(pow_m, pow_m, 64'(md));
			if (ex[bt])
				pow_m = mat_mul_mod(pow_m, step_m, 64'(md));
		end
		return pow_m[0][3];
	endfunction

	assign pending = term_queue.size();

	// Track the modulus, predict on each request, compare each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			errors <= 0;
			term_queue.delete();
		end else begin
			if (cfg_we)
				modulus_q <= cfg_wdata;
			if (in_ch.valid && in_ch.ready)
				term_queue.insert(term_queue.size(), recurrence_term(in_ch.term_index,
					in_ch.coeff_a, in_ch.coeff_b, in_ch.coeff_c, modulus_q));
			if (out_ch.valid && out_ch.ready) begin
				if (term_queue.size() == 0) begin
					$error("term_value: no result expected, got %0d", out_ch.term_value);
					errors <= errors + 1;
				end else begin
					if (out_ch.term_value !== term_queue[0]) begin
						$error("term_value: expected %0d, got %0d", term_queue[0],
							out_ch.term_value);
						errors <= errors + 1;
					end
					void'(term_queue.pop_front());
				end
			end
		end
	end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import lrmp_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [MOD_W-1:0] cfg_wdata = '0;
	int errors;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_go = 0;
	logic hold_on = 0;

	lrmp_in_if in_ch ();
	lrmp_out_if out_ch ();

	linear_recurrence_matrix_power_mod_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	lrmp_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.sink),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.term_index = '0;
		in_ch.coeff_a = '0;
		in_ch.coeff_b = '0;
		in_ch.coeff_c = '0;
		out_ch.ready = 0;
	end

	// Long receiver hold-off, counted here
	initial begin
		@(posedge hold_go);
		@(posedge clk);
		hold_on <= 1;
		repeat (15000) @(posedge clk);
		hold_on <= 0;
	end

	// Random receiver stalls
	always @(posedge clk)
		out_ch.ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);

	// Offer one request, idling first at random; valid stays up for back-to-back
	task automatic send_request(logic [TERM_W-1:0] n, logic [COEF_W-1:0] a,
			logic [COEF_W-1:0] b, logic [COEF_W-1:0] c);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_ch.valid <= 1;
		in_ch.term_index <= n;
		in_ch.coeff_a <= a;
		in_ch.coeff_b <= b;
		in_ch.coeff_c <= c;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drain all results, let the block settle, then write the modulus
	task automatic set_modulus(logic [MOD_W-1:0] md);
		in_ch.valid <= 0;
		@(negedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= md;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_random();
		logic [TERM_W-1:0] n;
		logic [COEF_W-1:0] cf[3];
		n = ($urandom_range(0, 99) < 65) ? TERM_W'($urandom_range(0, 60)) : $urandom;
		for (int i = 0; i < 3; i++)
			case ($urandom_range(0, 7))
				0: cf[i] = '0;
				1: cf[i] = '1;
				default: cf[i] = COEF_W'($urandom);
			endcase
		send_request(n, cf[0], cf[1], cf[2]);
	endtask

	initial begin
		logic [MOD_W-1:0] moduli[4];
		moduli = '{16'd65535, 16'd2, 16'd97, 16'd0};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Small indices, extremes of coefficients and index, reset modulus
		for (int n = 0; n <= 6; n++)
			send_request(n, 16'd1, 16'd1, 16'd1);
		send_request(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(32'h8000_0001, 16'd3, 16'd0, 16'd5);
		send_request(32'd100, 16'd0, 16'd0, 16'd0);
		send_request(32'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);

		// Degenerate moduli answer zero, then the largest modulus
		set_modulus(16'd0);
		send_request(32'd50, 16'd7, 16'd8, 16'd9);
		send_request(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'd1);
		set_modulus(16'd1);
		send_request(32'd50, 16'd7, 16'd8, 16'd9);
		send_request(32'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		set_modulus(16'd65535);
		send_request(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(32'd3, 16'hFFFF, 16'hFFFF, 16'hFFFE);

		// Random phases: receiver hold-off, sender idle, receiver stall, both, then none with a random modulus
		for (int ph = 0; ph < 5; ph++) begin
			set_modulus(ph < 4 ? moduli[ph] : 16'($urandom_range(2, 65535)));
			case (ph)
				1: begin send_idle_pct = 53; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 53; end
				3: begin send_idle_pct = 12; recv_stall_pct = 12; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (ph == 0)
				hold_go <= 1;
			for (int i = 0; i < 25; i++)
				send_random();
		end
		in_ch.valid <= 0;

		@(negedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#50ms;
		$display("tb: done, errors");
		$finish;
	end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lrmp_pkg.sv
rtl/core/lrmp_if.sv
rtl/core/lrmp_mudiv.sv
rtl/core/lrmp_ctrl.sv
rtl/core/lrmp_dp.sv
rtl/core/linear_recurrence_matrix_power_mod_core.sv
tb/lrmp_checker.sv
tb/tb.sv
